// ----- sv/scp_pkg.sv -----
// ============================================================================
// scp_pkg
// Shared constants, register indexes, the settings struct and width helpers
// for the side-chain compressor.
// ============================================================================
package scp_pkg;

   localparam int DEF_SAMPLE_BITS = 24;
   localparam int MAIN_LANES      = 2;
   localparam int SIDE_LANES      = 2;

   localparam int THR_BITS        = 24;
   localparam int COEF_BITS       = 17;
   localparam int MAKEUP_BITS     = 21;
   localparam int COUNT_BITS      = 2;
   localparam int GAIN_BITS       = 17;

   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 24;

   localparam int MUL_CHUNK_BITS  = 24;
   localparam int QUEUE_DEPTH     = 2;

   // Register indexes of the settings port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RATIO_SLOPE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_COEFF    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_COEFF   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAKEUP_GAIN     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAIN_USED       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIDE_USED       = 3'd6;

   localparam logic [THR_BITS-1:0]    THR_MAX    = 24'd8388608;
   localparam logic [COEF_BITS-1:0]   Q16_ONE    = 17'd65536;
   localparam logic [MAKEUP_BITS-1:0] MAKEUP_RST = 21'd65536;
   localparam logic [COUNT_BITS-1:0]  MAX_USED   = 2'd2;
   localparam logic [COUNT_BITS-1:0]  MAIN_RST   = 2'd2;
   localparam logic [COUNT_BITS-1:0]  SIDE_RST   = 2'd0;

   typedef struct packed {
      logic [THR_BITS-1:0]    threshold_level;
      logic [COEF_BITS-1:0]   ratio_slope;
      logic [COEF_BITS-1:0]   attack_coeff;
      logic [COEF_BITS-1:0]   release_coeff;
      logic [MAKEUP_BITS-1:0] makeup_gain;
      logic [COUNT_BITS-1:0]  main_count;
      logic [COUNT_BITS-1:0]  side_count;
   } scp_cfg_type;

   // Detector level plus two lanes of magnitude, sign and enable.
   function automatic int entry_bits(input int sample_bits);
      return (sample_bits + 16) + 2 * (sample_bits + 2);
   endfunction

   // Number of 24-bit slices of the widest operand of the shared multiplier.
   function automatic int mul_chunks(input int sample_bits);
      return (sample_bits + MAKEUP_BITS + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
   endfunction

   function automatic logic [COUNT_BITS-1:0] lane_count(input logic [COUNT_BITS-1:0] used,
                                                       input int lanes);
      logic [COUNT_BITS-1:0] limit;
      limit = (lanes < 2) ? COUNT_BITS'(lanes) : MAX_USED;
      return (used > limit) ? limit : used;
   endfunction

endpackage

// ----- sv/scp_if.sv -----
// ============================================================================
// scp_if
// Valid/ready channels of the side-chain compressor: audio frame requests,
// processed results and settings writes.
// ============================================================================
interface scp_req_if #(parameter int SAMPLE_BITS = scp_pkg::DEF_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] main_sample_a;
   logic signed [SAMPLE_BITS-1:0] main_sample_b;
   logic signed [SAMPLE_BITS-1:0] side_sample_a;
   logic signed [SAMPLE_BITS-1:0] side_sample_b;

   modport source (output valid, main_sample_a, main_sample_b, side_sample_a, side_sample_b,
                   input ready);
   modport sink   (input valid, main_sample_a, main_sample_b, side_sample_a, side_sample_b,
                   output ready);
endinterface

interface scp_rsp_if #(parameter int SAMPLE_BITS = scp_pkg::DEF_SAMPLE_BITS);
   import scp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] main_out_a;
   logic signed [SAMPLE_BITS-1:0] main_out_b;
   logic [GAIN_BITS-1:0]          compression_gain;

   modport source (output valid, main_out_a, main_out_b, compression_gain, input ready);
   modport sink   (input valid, main_out_a, main_out_b, compression_gain, output ready);
endinterface

interface scp_csr_if;
   import scp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/sidechain_compressor.sv -----
// ============================================================================
// sidechain_compressor
// Feed-forward side-chain compressor for one audio frame per request.
// ============================================================================
// Usage. A request on req_chan carries two main and two side-chain samples.
// The side-chain magnitudes in use drive an attack/release envelope; above
// the threshold the envelope sets a compression gain, and each main sample in
// use leaves on rsp_chan scaled by that gain and the make-up gain, saturated
// to the sample width, together with the gain itself. Unused main lanes
// return zero. Settings are written on csr_chan, which is always ready; they
// should change only while no request is in flight.
// Timing: the gain sequencer runs the gain divider only when the envelope is
// above the threshold. The divider yields one quotient bit a cycle, and the
// shared multiplier takes 24 operand bits a cycle. The result register is
// loaded as the sequencer finishes with the request.
// A two-deep queue sits between request intake and the sequencer, and the
// result register parts the sequencer from the receiver. While the receiver
// stalls, the result holds, the sequencer waits with the next result, and
// req_chan.ready drops once the queue is full.
// Reset loads the settings defaults, clears the envelope, the queue and the
// result valid; no clearing pass is needed.
// ============================================================================
module sidechain_compressor #(
   parameter int SAMPLE_BITS = scp_pkg::DEF_SAMPLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   scp_req_if.sink    req_chan,
   scp_rsp_if.source  rsp_chan,
   scp_csr_if.sink    csr_chan
);
   import scp_pkg::*;

   localparam int ENTRY_BITS = entry_bits(SAMPLE_BITS);

   // Settings registers, raw as written.
   logic [THR_BITS-1:0]    threshold_level_ff, threshold_level_in;
   logic [COEF_BITS-1:0]   ratio_slope_ff, ratio_slope_in;
   logic [COEF_BITS-1:0]   attack_coeff_ff, attack_coeff_in;
   logic [COEF_BITS-1:0]   release_coeff_ff, release_coeff_in;
   logic [MAKEUP_BITS-1:0] makeup_gain_ff, makeup_gain_in;
   logic [COUNT_BITS-1:0]  main_used_ff, main_used_in;
   logic [COUNT_BITS-1:0]  side_used_ff, side_used_in;

   scp_cfg_type            cfg;
   logic                   push_valid, push_ready;
   logic [ENTRY_BITS-1:0]  push_data;
   logic                   pop_valid, pop_ready;
   logic [ENTRY_BITS-1:0]  pop_data;

   // The settings port never stalls.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      threshold_level_in = threshold_level_ff;
      ratio_slope_in     = ratio_slope_ff;
      attack_coeff_in    = attack_coeff_ff;
      release_coeff_in   = release_coeff_ff;
      makeup_gain_in     = makeup_gain_ff;
      main_used_in       = main_used_ff;
      side_used_in       = side_used_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_THRESHOLD_LEVEL: threshold_level_in = csr_chan.data[THR_BITS-1:0];
            REG_RATIO_SLOPE:     ratio_slope_in     = csr_chan.data[COEF_BITS-1:0];
            REG_ATTACK_COEFF:    attack_coeff_in    = csr_chan.data[COEF_BITS-1:0];
            REG_RELEASE_COEFF:   release_coeff_in   = csr_chan.data[COEF_BITS-1:0];
            REG_MAKEUP_GAIN:     makeup_gain_in     = csr_chan.data[MAKEUP_BITS-1:0];
            REG_MAIN_USED:       main_used_in       = csr_chan.data[COUNT_BITS-1:0];
            REG_SIDE_USED:       side_used_in       = csr_chan.data[COUNT_BITS-1:0];
            default: begin
               // Writes to an unassigned index are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_level_ff <= THR_MAX;
         ratio_slope_ff     <= Q16_ONE;
         attack_coeff_ff    <= '0;
         release_coeff_ff   <= '0;
         makeup_gain_ff     <= MAKEUP_RST;
         main_used_ff       <= MAIN_RST;
         side_used_ff       <= SIDE_RST;
      end else begin
         threshold_level_ff <= threshold_level_in;
         ratio_slope_ff     <= ratio_slope_in;
         attack_coeff_ff    <= attack_coeff_in;
         release_coeff_ff   <= release_coeff_in;
         makeup_gain_ff     <= makeup_gain_in;
         main_used_ff       <= main_used_in;
         side_used_ff       <= side_used_in;
      end
   end

   // Settings as the datapath sees them: coefficients and ratio no larger than
   // unity, threshold no larger than full scale, lane counts within the lanes.
   always_comb begin
      cfg.threshold_level = (threshold_level_ff > THR_MAX) ? THR_MAX : threshold_level_ff;
      cfg.ratio_slope     = (ratio_slope_ff > Q16_ONE) ? Q16_ONE : ratio_slope_ff;
      cfg.attack_coeff    = (attack_coeff_ff > Q16_ONE) ? Q16_ONE : attack_coeff_ff;
      cfg.release_coeff   = (release_coeff_ff > Q16_ONE) ? Q16_ONE : release_coeff_ff;
      cfg.makeup_gain     = makeup_gain_ff;
      cfg.main_count      = lane_count(main_used_ff, MAIN_LANES);
      cfg.side_count      = lane_count(side_used_ff, SIDE_LANES);
   end

   scp_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .cfg        (cfg),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   scp_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   scp_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sv/scp_front.sv -----
// ============================================================================
// scp_front
// Takes a frame request, forms the side-chain detector level and the main
// sample magnitudes, and pushes them into the work queue.
// ============================================================================
module scp_front #(
   parameter int SAMPLE_BITS = scp_pkg::DEF_SAMPLE_BITS
) (
   input  scp_pkg::scp_cfg_type                          cfg,
   scp_req_if.sink                                       req_chan,
   output logic                                          push_valid,
   input  logic                                          push_ready,
   output logic [scp_pkg::entry_bits(SAMPLE_BITS)-1:0]   push_data
);
   import scp_pkg::*;

   localparam int S        = SAMPLE_BITS;
   localparam int DET_BITS = S + 16;

   function automatic logic [S-1:0] mag_of(input logic [S-1:0] raw);
      return raw[S-1] ? (~raw + 1'b1) : raw;
   endfunction

   logic [S-1:0]        main_a_raw, main_b_raw, side_a_raw, side_b_raw;
   logic [S-1:0]        side_a_mag, side_b_mag;
   logic [S:0]          side_sum;
   logic [DET_BITS-1:0] det;
   logic                use_a, use_b;

   assign main_a_raw = req_chan.main_sample_a;
   assign main_b_raw = req_chan.main_sample_b;
   assign side_a_raw = req_chan.side_sample_a;
   assign side_b_raw = req_chan.side_sample_b;

   assign side_a_mag = mag_of(side_a_raw);
   assign side_b_mag = mag_of(side_b_raw);
   assign side_sum   = {1'b0, side_a_mag} + {1'b0, side_b_mag};

   // Average of the magnitudes in Q1.(S+15): the divide by one or two is a shift.
   always_comb begin
      case (cfg.side_count)
         2'd1:    det = {side_a_mag, 16'b0};
         2'd2:    det = {side_sum, 15'b0};
         default: det = '0;
      endcase
   end

   assign use_a = (cfg.main_count >= 2'd1);
   assign use_b = (cfg.main_count >= 2'd2);

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = {det,
                            mag_of(main_a_raw), main_a_raw[S-1], use_a,
                            mag_of(main_b_raw), main_b_raw[S-1], use_b};

endmodule

// ----- sv/scp_queue.sv -----
// ============================================================================
// scp_queue
// Short FIFO that decouples the request front from the gain sequencer.
// ============================================================================
module scp_queue #(
   parameter int WIDTH = scp_pkg::entry_bits(scp_pkg::DEF_SAMPLE_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import scp_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] ptr);
      return (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = (count_ff != (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/scp_back.sv -----
// ============================================================================
// scp_back
// Gain sequencer: envelope update, compression gain by a bit-serial divider,
// and make-up scaling of each main lane, using one shared chunked multiplier
// for all but the make-up product. Holds the result register of the response channel.
// ============================================================================
module scp_back #(
   parameter int SAMPLE_BITS = scp_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  scp_pkg::scp_cfg_type                          cfg,
   input  logic                                          pop_valid,
   output logic                                          pop_ready,
   input  logic [scp_pkg::entry_bits(SAMPLE_BITS)-1:0]   pop_data,
   scp_rsp_if.source                                     rsp_chan
);
   import scp_pkg::*;

   localparam int S          = SAMPLE_BITS;
   localparam int ENV_BITS   = S + 16;
   localparam int NUM_BITS   = ENV_BITS + 16;
   localparam int MUL_CHUNKS = mul_chunks(S);
   localparam int MX_BITS    = MUL_CHUNKS * MUL_CHUNK_BITS;
   localparam int ACC_BITS   = MX_BITS + COEF_BITS;
   localparam int QW         = ACC_BITS - 32;
   localparam int CNT_BITS   = $clog2(GAIN_BITS);
   localparam logic [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(64'h8000_0000);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ENV_MUL  = 4'd1;
   localparam logic [3:0] ST_ENV_UPD  = 4'd2;
   localparam logic [3:0] ST_GAIN_SET = 4'd3;
   localparam logic [3:0] ST_NUM_MUL  = 4'd4;
   localparam logic [3:0] ST_DIV_SET  = 4'd5;
   localparam logic [3:0] ST_DIV      = 4'd6;
   localparam logic [3:0] ST_OUT_SET  = 4'd7;
   localparam logic [3:0] ST_OUT_MUL  = 4'd8;
   localparam logic [3:0] ST_OUT_RND  = 4'd9;
   localparam logic [3:0] ST_DONE     = 4'd10;

   // Queue entry fields.
   logic [ENV_BITS-1:0] e_det;
   logic [S-1:0]        e_mag_a, e_mag_b;
   logic                e_neg_a, e_neg_b, e_use_a, e_use_b;

   assign {e_det, e_mag_a, e_neg_a, e_use_a, e_mag_b, e_neg_b, e_use_b} = pop_data;

   logic [3:0]           state_ff, state_in;
   logic [ENV_BITS-1:0]  env_ff, env_in;
   logic                 up_ff, up_in;
   logic [S-1:0]         mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic                 neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic                 use_a_ff, use_a_in, use_b_ff, use_b_in;
   logic [COEF_BITS-1:0] mul_c_ff, mul_c_in;
   logic [MX_BITS-1:0]   mul_x_ff, mul_x_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ENV_BITS-1:0]  rem_ff, rem_in;
   logic [GAIN_BITS-1:0] numlo_ff, numlo_in;
   logic [GAIN_BITS-1:0] quo_ff, quo_in;
   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   logic                 lane_ff, lane_in;
   logic [S-1:0]         res_a_ff, res_a_in, res_b_ff, res_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]         out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [GAIN_BITS-1:0] out_gain_ff, out_gain_in;

   // Datapath pieces.
   logic [COEF_BITS+MUL_CHUNK_BITS-1:0] chunk_prod;
   logic [ACC_BITS-1:0]                 acc_step;
   logic [MX_BITS-1:0]                  mul_x_step;
   logic                                chunk_last;
   logic                                det_gt, det_ge;
   logic [ENV_BITS-1:0]                 env_diff, delta, thr_ext;
   logic [NUM_BITS-1:0]                 num;
   logic [ENV_BITS:0]                   trial;
   logic                                trial_ge;
   logic [S-1:0]                        lane_mag;
   logic                                lane_neg, lane_use;
   logic [S+MAKEUP_BITS-1:0]            m_prod;
   logic [ACC_BITS-1:0]                 rounded;
   logic [QW-1:0]                       q_val, q_half;
   logic [S-1:0]                        mag_sat, lane_res;

   assign chunk_prod = mul_c_ff * mul_x_ff[MX_BITS-1 -: MUL_CHUNK_BITS];
   assign acc_step   = {acc_ff[ACC_BITS-MUL_CHUNK_BITS-1:0], {MUL_CHUNK_BITS{1'b0}}}
                       + ACC_BITS'(chunk_prod);
   assign mul_x_step = {mul_x_ff[MX_BITS-MUL_CHUNK_BITS-1:0], {MUL_CHUNK_BITS{1'b0}}};
   assign chunk_last = (cnt_ff == CNT_BITS'(MUL_CHUNKS - 1));

   assign det_gt   = (e_det > env_ff);
   assign det_ge   = (e_det >= env_ff);
   assign env_diff = det_ge ? (e_det - env_ff) : (env_ff - e_det);
   assign delta    = acc_ff[16 +: ENV_BITS];
   assign thr_ext  = ENV_BITS'(cfg.threshold_level) << (S - 8);

   assign num      = NUM_BITS'(acc_ff) + {thr_ext, 16'b0};
   assign trial    = {rem_ff, numlo_ff[GAIN_BITS-1]};
   assign trial_ge = (trial >= {1'b0, env_ff});

   assign lane_mag = lane_ff ? mag_b_ff : mag_a_ff;
   assign lane_neg = lane_ff ? neg_b_ff : neg_a_ff;
   assign lane_use = lane_ff ? use_b_ff : use_a_ff;
   assign m_prod   = lane_mag * cfg.makeup_gain;

   // Round to nearest, then saturate the magnitude to the signed sample range.
   assign rounded = acc_ff + ROUND_BIAS;
   assign q_val   = rounded[ACC_BITS-1:32];
   assign q_half  = QW'(1) << (S - 1);

   always_comb begin
      if (lane_neg) begin
         mag_sat  = (q_val > q_half) ? q_half[S-1:0] : q_val[S-1:0];
         lane_res = ~mag_sat + 1'b1;
      end else begin
         mag_sat  = (q_val >= q_half) ? (q_half[S-1:0] - 1'b1) : q_val[S-1:0];
         lane_res = mag_sat;
      end
   end

   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      env_in       = env_ff;
      up_in        = up_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;
      use_a_in     = use_a_ff;
      use_b_in     = use_b_ff;
      mul_c_in     = mul_c_ff;
      mul_x_in     = mul_x_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      numlo_in     = numlo_ff;
      quo_in       = quo_ff;
      gain_in      = gain_ff;
      lane_in      = lane_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_gain_in  = out_gain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               mag_a_in = e_mag_a;
               mag_b_in = e_mag_b;
               neg_a_in = e_neg_a;
               neg_b_in = e_neg_b;
               use_a_in = e_use_a;
               use_b_in = e_use_b;
               up_in    = det_ge;
               mul_c_in = det_gt ? cfg.attack_coeff : cfg.release_coeff;
               mul_x_in = MX_BITS'(env_diff);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_ENV_MUL;
            end
         end
         ST_ENV_MUL, ST_NUM_MUL, ST_OUT_MUL: begin
            acc_in   = acc_step;
            mul_x_in = mul_x_step;
            cnt_in   = cnt_ff + 1'b1;
            if (chunk_last) begin
               cnt_in = '0;
               case (state_ff)
                  ST_ENV_MUL: state_in = ST_ENV_UPD;
                  ST_NUM_MUL: state_in = ST_DIV_SET;
                  default:    state_in = ST_OUT_RND;
               endcase
            end
         end
         ST_ENV_UPD: begin
            env_in   = up_ff ? (env_ff + delta) : (env_ff - delta);
            state_in = ST_GAIN_SET;
         end
         ST_GAIN_SET: begin
            lane_in = 1'b0;
            if (env_ff > thr_ext) begin
               mul_c_in = cfg.ratio_slope;
               mul_x_in = MX_BITS'(env_ff - thr_ext);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_NUM_MUL;
            end else begin
               gain_in  = Q16_ONE;
               state_in = ST_OUT_SET;
            end
         end
         ST_DIV_SET: begin
            // The quotient is at most unity, so the top bits already sit below the level.
            rem_in   = ENV_BITS'(num[NUM_BITS-1:GAIN_BITS]);
            numlo_in = num[GAIN_BITS-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = trial_ge ? ENV_BITS'(trial - {1'b0, env_ff}) : trial[ENV_BITS-1:0];
            quo_in   = {quo_ff[GAIN_BITS-2:0], trial_ge};
            numlo_in = {numlo_ff[GAIN_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(GAIN_BITS - 1)) begin
               gain_in  = quo_in;
               cnt_in   = '0;
               state_in = ST_OUT_SET;
            end
         end
         ST_OUT_SET: begin
            mul_x_in = MX_BITS'(m_prod);
            mul_c_in = gain_ff;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_OUT_MUL;
         end
         ST_OUT_RND: begin
            if (lane_ff) begin
               res_b_in = lane_use ? lane_res : '0;
               state_in = ST_DONE;
            end else begin
               res_a_in = lane_use ? lane_res : '0;
               lane_in  = 1'b1;
               state_in = ST_OUT_SET;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_a_in     = res_a_ff;
               out_b_in     = res_b_ff;
               out_gain_in  = gain_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      mag_a_ff    <= mag_a_in;
      mag_b_ff    <= mag_b_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      use_a_ff    <= use_a_in;
      use_b_ff    <= use_b_in;
      mul_c_ff    <= mul_c_in;
      mul_x_ff    <= mul_x_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      numlo_ff    <= numlo_in;
      quo_ff      <= quo_in;
      gain_ff     <= gain_in;
      lane_ff     <= lane_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_gain_ff <= out_gain_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.main_out_a       = out_a_ff;
   assign rsp_chan.main_out_b       = out_b_ff;
   assign rsp_chan.compression_gain = out_gain_ff;

endmodule

// ----- sv/scp_check.sv -----
// ============================================================================
// scp_check
// Port-level checks of the side-chain compressor: results held while stalled
// and offered only against requests taken, bounded occupancy and reset behavior.
// ============================================================================
module scp_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   import scp_pkg::*;

   // Queue slots, the frame in the sequencer and the result register.
   localparam int MAX_HELD = QUEUE_DEPTH + 2;
   localparam int CNT_BITS = $clog2(MAX_HELD + 1) + 1;

   logic [CNT_BITS-1:0] held_ff, held_in;

   assign held_in = held_ff + CNT_BITS'(req_valid && req_ready)
                    - CNT_BITS'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held_ff != '0)
      else $error("result offered with no request outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_BITS'(MAX_HELD))
      else $error("more requests outstanding than the block can hold");

endmodule

bind sidechain_compressor scp_check u_scp_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
